@@ hw/rtl/nns_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler package
// Widths, register indexes and reset values shared by the scaler core and its
// scale-factor divider.
// ----------------------------------------------------------------------------
package nns_pkg;

	// Frame geometry and pixel widths.
	localparam int SIZE_W    = 12;
	localparam int FRAC_W    = 16;
	localparam int SCALE_W   = SIZE_W + FRAC_W;
	localparam int COORD_W   = 11;
	localparam int ADDR_W    = 20;
	localparam int PIX_W     = 32;
	localparam int PROD_W    = COORD_W + SCALE_W;
	localparam int IDX_W     = 2 * SIZE_W;
	localparam int DIV_CNT_W = $clog2(SCALE_W + 1);

	// Frame store depth in pixels.
	localparam int MAX_SRC_PIXELS = 1048576;
	localparam int MEM_AW         = $clog2(MAX_SRC_PIXELS);

	// Configuration port.
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 3'd0,
		CFG_SRC_HEIGHT = 3'd1,
		CFG_DST_WIDTH  = 3'd2,
		CFG_DST_HEIGHT = 3'd3,
		CFG_OUT_16BIT  = 3'd4
	} cfg_reg_t;

	// Register reset values.
	localparam logic [SIZE_W-1:0] DST_WIDTH_RST  = SIZE_W'(1280);
	localparam logic [SIZE_W-1:0] DST_HEIGHT_RST = SIZE_W'(720);

	// Request codes.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

endpackage

@@ hw/rtl/nearest_neighbor_scaler_rgb565_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler core, BGRA or RGB565 output
// Holds a BGRA source frame in a single-port memory and returns, for each
// read request, the source pixel nearest to an output coordinate.
//
// Channel  Handshake              Payload
// in       in_valid / in_ready    req_type, pixel_addr, pixel_bgra, out_x, out_y
// out      out_valid / out_ready  pixel_out, no_frame
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request enters per cycle while the input is not stalled; a read passes
// every pipeline stage before out_valid rises. Writes and reads share the
// memory port at the third stage, in request order, so a read sees every
// earlier write. Size register writes stall input during the bit-serial divide.
// A configuration word waits for an empty pipeline and holds off requests.
// Reset needs no clearing pass; a stalled output stops only full stages.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_rgb565_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [nns_pkg::ADDR_W-1:0]    pixel_addr,
	input  logic [nns_pkg::PIX_W-1:0]     pixel_bgra,
	input  logic [nns_pkg::COORD_W-1:0]   out_x,
	input  logic [nns_pkg::COORD_W-1:0]   out_y,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nns_pkg::PIX_W-1:0]     pixel_out,
	output logic                          no_frame,
	// Configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nns_pkg::SIZE_W-1:0]    cfg_data
);

	// Configuration registers
	logic [nns_pkg::SIZE_W-1:0]  src_width_q;
	logic [nns_pkg::SIZE_W-1:0]  src_height_q;
	logic [nns_pkg::SIZE_W-1:0]  dst_width_q;
	logic [nns_pkg::SIZE_W-1:0]  dst_height_q;
	logic                        out_16bit_q;
	logic                        restart_q;

	// Scale factors
	logic [nns_pkg::SCALE_W-1:0] scale_x;
	logic [nns_pkg::SCALE_W-1:0] scale_y;
	logic                        busy_x;
	logic                        busy_y;
	logic                        scale_busy;

	// Pipeline
	logic                        in_acc;
	logic                        cfg_acc;
	logic                        rdy1, rdy2, rdy3, rdy4;
	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        wr_s1, wr_s2, wr_s3;
	logic [nns_pkg::ADDR_W-1:0]  addr_s1, addr_s2, addr_s3;
	logic [nns_pkg::PIX_W-1:0]   bgra_s1, bgra_s2, bgra_s3;
	logic [nns_pkg::PROD_W-1:0]  px_s1, py_s1;
	logic [nns_pkg::SIZE_W-1:0]  sx_s2, sy_s2;
	logic [nns_pkg::IDX_W-1:0]   idx_s3;
	logic                        nf_s4;
	logic                        oob_s4;
	logic [nns_pkg::PIX_W-1:0]   rdata_s4;

	// Memory port
	logic [nns_pkg::IDX_W-1:0]   acc_idx;
	logic                        acc_in_range;
	logic [nns_pkg::MEM_AW-1:0]  mem_addr;
	logic                        mem_we;
	logic                        mem_re;
	logic [nns_pkg::PIX_W-1:0]   store_mem [nns_pkg::MAX_SRC_PIXELS];

	// Scaled coordinate, clamped to the last source column or row.
	function automatic logic [nns_pkg::SIZE_W-1:0] clamp_coord(
		input logic [nns_pkg::PROD_W-1:0] prod,
		input logic [nns_pkg::SIZE_W-1:0] size
	);
		logic [nns_pkg::PROD_W-nns_pkg::FRAC_W-1:0] s;
		logic [nns_pkg::SIZE_W-1:0]                 r;
		begin
			s = prod[nns_pkg::PROD_W-1:nns_pkg::FRAC_W];
			if (s >= (nns_pkg::PROD_W-nns_pkg::FRAC_W)'(size)) begin
				r = (size == '0) ? '0 : size - nns_pkg::SIZE_W'(1);
			end else begin
				r = s[nns_pkg::SIZE_W-1:0];
			end
			return r;
		end
	endfunction

	// BGRA to RGB565 in the low half word.
	function automatic logic [nns_pkg::PIX_W-1:0] to_rgb565(
		input logic [nns_pkg::PIX_W-1:0] p
	);
		begin
			return {16'h0000, p[23:19], p[15:10], p[7:3]};
		end
	endfunction

	// Configuration writes; a size change restarts both dividers next cycle.
	// A word is taken only once every stage is empty.
	assign cfg_ready = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= '0;
			src_height_q <= '0;
			dst_width_q  <= nns_pkg::DST_WIDTH_RST;
			dst_height_q <= nns_pkg::DST_HEIGHT_RST;
			out_16bit_q  <= 1'b0;
			restart_q    <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (cfg_acc) begin
				unique case (cfg_index)
					nns_pkg::CFG_SRC_WIDTH: begin
						src_width_q <= cfg_data;
						restart_q   <= 1'b1;
					end
					nns_pkg::CFG_SRC_HEIGHT: begin
						src_height_q <= cfg_data;
						restart_q    <= 1'b1;
					end
					nns_pkg::CFG_DST_WIDTH: begin
						dst_width_q <= cfg_data;
						restart_q   <= 1'b1;
					end
					nns_pkg::CFG_DST_HEIGHT: begin
						dst_height_q <= cfg_data;
						restart_q    <= 1'b1;
					end
					nns_pkg::CFG_OUT_16BIT: begin
						out_16bit_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Scale factor dividers, one per axis.
	nns_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (restart_q),
		.src_size (src_width_q),
		.dst_size (dst_width_q),
		.busy     (busy_x),
		.quot     (scale_x)
	);

	nns_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (restart_q),
		.src_size (src_height_q),
		.dst_size (dst_height_q),
		.busy     (busy_y),
		.quot     (scale_y)
	);

	assign scale_busy = restart_q || busy_x || busy_y;

	// Stage readiness; a write leaves stage 3 without needing the output stage.
	// A pending configuration word keeps new requests out.
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || wr_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1 && !scale_busy && !cfg_valid;
	assign in_acc   = in_valid && in_ready;

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_acc;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3 && !wr_s3;
			end
		end
	end

	// Stage 1: coordinate times scale factor.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_s1   <= (req_type == nns_pkg::REQ_WRITE);
			addr_s1 <= pixel_addr;
			bgra_s1 <= pixel_bgra;
			px_s1   <= nns_pkg::PROD_W'(out_x) * nns_pkg::PROD_W'(scale_x);
			py_s1   <= nns_pkg::PROD_W'(out_y) * nns_pkg::PROD_W'(scale_y);
		end
	end

	// Stage 2: drop the fraction and clamp to the source edge.
	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			wr_s2   <= wr_s1;
			addr_s2 <= addr_s1;
			bgra_s2 <= bgra_s1;
			sx_s2   <= clamp_coord(px_s1, src_width_q);
			sy_s2   <= clamp_coord(py_s1, src_height_q);
		end
	end

	// Stage 3: linear source index.
	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			wr_s3   <= wr_s2;
			addr_s3 <= addr_s2;
			bgra_s3 <= bgra_s2;
			idx_s3  <= nns_pkg::IDX_W'(sy_s2) * nns_pkg::IDX_W'(src_width_q)
			         + nns_pkg::IDX_W'(sx_s2);
		end
	end

	// Memory access: the write address or the read index, whichever is in stage 3.
	always_comb begin
		acc_idx      = wr_s3 ? nns_pkg::IDX_W'(addr_s3) : idx_s3;
		acc_in_range = (acc_idx < nns_pkg::IDX_W'(nns_pkg::MAX_SRC_PIXELS));
		mem_addr     = acc_idx[nns_pkg::MEM_AW-1:0];
		mem_we       = v_s3 && wr_s3 && acc_in_range;
		mem_re       = v_s3 && !wr_s3 && rdy4 && acc_in_range;
	end

	// Frame store, one port, registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_addr] <= bgra_s3;
		end
		if (mem_re) begin
			rdata_s4 <= store_mem[mem_addr];
		end
	end

	// Stage 4: result flags that travel with the read data.
	always_ff @(posedge clk) begin
		if (v_s3 && !wr_s3 && rdy4) begin
			nf_s4  <= (src_width_q == '0);
			oob_s4 <= !acc_in_range;
		end
	end

	// Result word.
	always_comb begin
		out_valid = v_s4;
		no_frame  = nf_s4;
		if (nf_s4 || oob_s4) begin
			pixel_out = '0;
		end else if (out_16bit_q) begin
			pixel_out = to_rgb565(rdata_s4);
		end else begin
			pixel_out = rdata_s4;
		end
	end

`ifndef SYNTHESIS
	// The single memory port never serves a read and a write together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame store read and write in the same cycle");

	// A read that leaves stage 3 always becomes a result word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !wr_s3 && rdy4) |=> v_s4)
		else $error("read lost between stage 3 and the output");

	// A read held in stage 3 stays there while the output stage is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !wr_s3 && !rdy4) |=> v_s3)
		else $error("read dropped from stage 3 while stalled");

	// A no-frame result carries a zero pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_frame) |-> (pixel_out == '0))
		else $error("no-frame result with nonzero pixel");
`endif

endmodule

@@ hw/rtl/nns_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scale-factor divider
// Restoring divider that forms (src_size << FRAC_W) / dst_size one quotient
// bit per cycle. A destination size of zero divides by one.
// ----------------------------------------------------------------------------
module nns_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nns_pkg::SIZE_W-1:0]  src_size,
	input  logic [nns_pkg::SIZE_W-1:0]  dst_size,
	output logic                        busy,
	output logic [nns_pkg::SCALE_W-1:0] quot
);

	logic                          busy_q;
	logic [nns_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [nns_pkg::SIZE_W-1:0]    rem_q;
	logic [nns_pkg::SIZE_W-1:0]    div_q;
	logic [nns_pkg::SCALE_W-1:0]   quot_q;
	logic [nns_pkg::SIZE_W:0]      trial;
	logic                          qbit;

	// Trial subtraction for the next quotient bit.
	always_comb begin
		trial = {rem_q, quot_q[nns_pkg::SCALE_W-1]};
		qbit  = (trial >= {1'b0, div_q});
	end

	// The quotient register starts out holding the dividend and shifts the
	// quotient bits in from the bottom as the dividend bits leave the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			quot_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nns_pkg::DIV_CNT_W'(nns_pkg::SCALE_W);
			rem_q  <= '0;
			div_q  <= (dst_size == '0) ? nns_pkg::SIZE_W'(1) : dst_size;
			quot_q <= {src_size, {nns_pkg::FRAC_W{1'b0}}};
		end else if (busy_q) begin
			rem_q  <= qbit ? nns_pkg::SIZE_W'(trial - {1'b0, div_q})
			               : trial[nns_pkg::SIZE_W-1:0];
			quot_q <= {quot_q[nns_pkg::SCALE_W-2:0], qbit};
			cnt_q  <= cnt_q - nns_pkg::DIV_CNT_W'(1);
			if (cnt_q == nns_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

@@ test/tb_nearest_neighbor_scaler_rgb565_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the nearest-neighbor scaler core
// A queue of requests feeds a clocked driver. A clocked monitor predicts every
// accepted read from its own copy of the frame store and the registers. It
// checks each returned word against the oldest prediction. A directed opening
// part covers the corner cases. Random phases follow, with several frame
// geometries, mostly with idle gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_scaler_rgb565_core;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 16;

	typedef struct {
		logic                       req;
		bit [nns_pkg::ADDR_W-1:0]   addr;
		bit [nns_pkg::PIX_W-1:0]    bgra;
		bit [nns_pkg::COORD_W-1:0]  ox;
		bit [nns_pkg::COORD_W-1:0]  oy;
	} pix_req_t;

	typedef struct {
		bit [nns_pkg::PIX_W-1:0] pixel;
		bit                      no_frame;
	} pix_result_t;

	// Clock and reset.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	// Block ports.
	logic                          in_valid   = 1'b0;
	logic                          in_ready;
	logic                          req_type   = nns_pkg::REQ_WRITE;
	logic [nns_pkg::ADDR_W-1:0]    pixel_addr = '0;
	logic [nns_pkg::PIX_W-1:0]     pixel_bgra = '0;
	logic [nns_pkg::COORD_W-1:0]   out_x      = '0;
	logic [nns_pkg::COORD_W-1:0]   out_y      = '0;
	logic                          out_valid;
	logic                          out_ready  = 1'b0;
	logic [nns_pkg::PIX_W-1:0]     pixel_out;
	logic                          no_frame;
	logic                          cfg_valid  = 1'b0;
	logic                          cfg_ready;
	logic [nns_pkg::CFG_IDX_W-1:0] cfg_index  = nns_pkg::CFG_SRC_WIDTH;
	logic [nns_pkg::SIZE_W-1:0]    cfg_data   = '0;

	nearest_neighbor_scaler_rgb565_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.pixel_addr (pixel_addr),
		.pixel_bgra (pixel_bgra),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.no_frame   (no_frame),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Predictor state: register copies and the frame contents seen so far.
	bit [nns_pkg::SIZE_W-1:0] m_src_w = '0;
	bit [nns_pkg::SIZE_W-1:0] m_src_h = '0;
	bit [nns_pkg::SIZE_W-1:0] m_dst_w = nns_pkg::DST_WIDTH_RST;
	bit [nns_pkg::SIZE_W-1:0] m_dst_h = nns_pkg::DST_HEIGHT_RST;
	bit                       m_out16 = 1'b0;
	bit [nns_pkg::PIX_W-1:0]  frame_copy [bit [nns_pkg::ADDR_W-1:0]];

	// Addresses that some queued write will fill, used to keep reads legal.
	bit              frame_filled [bit [nns_pkg::ADDR_W-1:0]];

	pix_req_t        frame_reqs [$];
	pix_result_t     due_pixels [$];
	pix_req_t        cur_req;

	bit              in_busy  = 1'b0;
	bit              in_taken = 1'b0;
	bit              hold_req = 1'b0;
	int              hold_cnt = 0;
	int              snd_idle_pct = 31;
	int              rcv_idle_pct = 48;
	int              err_cnt = 0;
	int              stall_cnt = 0;

	// Map one output coordinate to a source coordinate, clamped to the edge.
	function automatic bit [nns_pkg::SIZE_W-1:0] src_coord(
			bit [nns_pkg::COORD_W-1:0] pos,
			bit [nns_pkg::SIZE_W-1:0] src_size, bit [nns_pkg::SIZE_W-1:0] dst_size);
		bit [nns_pkg::SCALE_W-1:0] scale;
		bit [nns_pkg::PROD_W-1:0]  s;
		scale = {src_size, 16'b0} / ((dst_size == 0) ? nns_pkg::SCALE_W'(1)
			: nns_pkg::SCALE_W'(dst_size));
		s = (nns_pkg::PROD_W'(pos) * nns_pkg::PROD_W'(scale)) >> nns_pkg::FRAC_W;
		if (s >= nns_pkg::PROD_W'(src_size))
			s = (src_size != 0) ? nns_pkg::PROD_W'(src_size) - 1 : '0;
		return s[nns_pkg::SIZE_W-1:0];
	endfunction

	function automatic bit [nns_pkg::IDX_W-1:0] src_index(bit [nns_pkg::COORD_W-1:0] ox,
			bit [nns_pkg::COORD_W-1:0] oy);
		return nns_pkg::IDX_W'(src_coord(oy, m_src_h, m_dst_h)) * nns_pkg::IDX_W'(m_src_w)
			+ nns_pkg::IDX_W'(src_coord(ox, m_src_w, m_dst_w));
	endfunction

	// Expected word for one read under the current registers.
	function automatic pix_result_t scaled_pixel(pix_req_t r);
		pix_result_t res;
		bit [nns_pkg::IDX_W-1:0] idx;
		bit [nns_pkg::PIX_W-1:0] pix;
		if (m_src_w == 0) begin
			res.pixel = '0;
			res.no_frame = 1'b1;
			return res;
		end
		idx = src_index(r.ox, r.oy);
		pix = '0;
		if (idx < nns_pkg::MAX_SRC_PIXELS
				&& frame_copy.exists(idx[nns_pkg::ADDR_W-1:0]))
			pix = frame_copy[idx[nns_pkg::ADDR_W-1:0]];
		res.pixel = m_out16 ? {16'b0, pix[23:19], pix[15:10], pix[7:3]} : pix;
		res.no_frame = 1'b0;
		return res;
	endfunction

	// A read is legal when it reaches no frame entry that was never written.
	function automatic bit read_is_legal(bit [nns_pkg::COORD_W-1:0] ox,
			bit [nns_pkg::COORD_W-1:0] oy);
		bit [nns_pkg::IDX_W-1:0] idx;
		if (m_src_w == 0)
			return 1'b1;
		idx = src_index(ox, oy);
		return (idx >= nns_pkg::MAX_SRC_PIXELS)
			|| frame_filled.exists(idx[nns_pkg::ADDR_W-1:0]);
	endfunction

	task automatic report_mismatch(string msg);
		err_cnt++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic push_write(bit [nns_pkg::ADDR_W-1:0] addr, bit [nns_pkg::PIX_W-1:0] data);
		pix_req_t r;
		r.req  = nns_pkg::REQ_WRITE;
		r.addr = addr;
		r.bgra = data;
		r.ox   = nns_pkg::COORD_W'($urandom());
		r.oy   = nns_pkg::COORD_W'($urandom());
		frame_filled[addr] = 1'b1;
		frame_reqs.push_back(r);
	endtask

	task automatic push_read(bit [nns_pkg::COORD_W-1:0] ox, bit [nns_pkg::COORD_W-1:0] oy);
		pix_req_t r;
		r.req  = nns_pkg::REQ_READ;
		r.addr = nns_pkg::ADDR_W'($urandom());
		r.bgra = $urandom();
		r.ox   = ox;
		r.oy   = oy;
		frame_reqs.push_back(r);
	endtask

	// One register write over the configuration channel.
	task automatic write_reg(nns_pkg::cfg_reg_t idx, bit [nns_pkg::SIZE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(int sw, int sh, int dw, int dh, bit o16);
		write_reg(nns_pkg::CFG_SRC_WIDTH, nns_pkg::SIZE_W'(sw));
		write_reg(nns_pkg::CFG_SRC_HEIGHT, nns_pkg::SIZE_W'(sh));
		write_reg(nns_pkg::CFG_DST_WIDTH, nns_pkg::SIZE_W'(dw));
		write_reg(nns_pkg::CFG_DST_HEIGHT, nns_pkg::SIZE_W'(dh));
		write_reg(nns_pkg::CFG_OUT_16BIT, {11'($urandom()), o16});
	endtask

	// Wait until every word has returned and trailing writes have settled.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (frame_reqs.size() != 0 || in_busy || due_pixels.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// One random phase: mostly reads inside the output image, some writes.
	task automatic run_phase(int sw, int sh, int dw, int dh, bit o16, int n, bit stall_out);
		int region;
		int dwe;
		int dhe;
		bit [nns_pkg::COORD_W-1:0] ox;
		bit [nns_pkg::COORD_W-1:0] oy;
		bit found;
		wait_idle();
		set_frame(sw, sh, dw, dh, o16);
		region = sw * ((sh == 0) ? 1 : sh);
		if (region > nns_pkg::MAX_SRC_PIXELS)
			region = nns_pkg::MAX_SRC_PIXELS;
		dwe = (dw == 0) ? 1 : ((dw > 2048) ? 2048 : dw);
		dhe = (dh == 0) ? 1 : ((dh > 2048) ? 2048 : dh);
		// Small frames are filled completely up front.
		if (region > 0 && region <= 256)
			for (int a = 0; a < region; a++)
				push_write(nns_pkg::ADDR_W'(a), $urandom());
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(3) != 0 && region > 0)
					push_write(nns_pkg::ADDR_W'($urandom_range(region - 1)), $urandom());
				else
					push_write(nns_pkg::ADDR_W'($urandom()), $urandom());
			end else begin
				found = 1'b0;
				for (int t = 0; t < 30 && !found; t++) begin
					if ($urandom_range(99) < 85) begin
						ox = nns_pkg::COORD_W'($urandom_range(dwe - 1));
						oy = nns_pkg::COORD_W'($urandom_range(dhe - 1));
					end else begin
						ox = nns_pkg::COORD_W'($urandom_range(2047));
						oy = nns_pkg::COORD_W'($urandom_range(2047));
					end
					found = read_is_legal(ox, oy);
				end
				if (!found) begin
					ox = '0;
					oy = '0;
				end
				push_read(ox, oy);
			end
		end
		if (stall_out)
			hold_req = 1'b1;
	endtask

	// Request driver: offers queued words, with random gaps.
	always @(negedge clk) begin
		if (in_taken) begin
			in_busy  = 1'b0;
			in_taken = 1'b0;
		end
		if (!in_busy) begin
			if (arst_n && frame_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				cur_req = frame_reqs.pop_front();
				req_type   <= cur_req.req;
				pixel_addr <= cur_req.addr;
				pixel_bgra <= cur_req.bgra;
				out_x      <= cur_req.ox;
				out_y      <= cur_req.oy;
				in_valid   <= 1'b1;
				in_busy     = 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random back-pressure plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt != 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Monitor: predicts accepted requests, tracks registers, checks results.
	always @(posedge clk) begin
		pix_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				if (cur_req.req == nns_pkg::REQ_WRITE) begin
					if (cur_req.addr < nns_pkg::MAX_SRC_PIXELS)
						frame_copy[cur_req.addr] = cur_req.bgra;
				end else begin
					due_pixels.push_back(scaled_pixel(cur_req));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					nns_pkg::CFG_SRC_WIDTH:  m_src_w = cfg_data;
					nns_pkg::CFG_SRC_HEIGHT: m_src_h = cfg_data;
					nns_pkg::CFG_DST_WIDTH:  m_dst_w = cfg_data;
					nns_pkg::CFG_DST_HEIGHT: m_dst_h = cfg_data;
					nns_pkg::CFG_OUT_16BIT:  m_out16 = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (due_pixels.size() == 0) begin
					report_mismatch($sformatf("unexpected word pixel_out=%h no_frame=%b",
						pixel_out, no_frame));
				end else begin
					want = due_pixels.pop_front();
					if (pixel_out !== want.pixel)
						report_mismatch($sformatf("pixel_out %h, expected %h",
							pixel_out, want.pixel));
					if (no_frame !== want.no_frame)
						report_mismatch($sformatf("no_frame %b, expected %b",
							no_frame, want.no_frame));
				end
			end
		end
	end

	// Watchdog: ends the run when no channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			stall_cnt = 0;
		else
			stall_cnt++;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("nearest_neighbor_scaler_rgb565_core test failed");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// No frame after reset; writes at both ends of the address range.
		push_write(0, 32'hFFFF_FFFF);
		push_write(20'hF_FFFF, 32'h0000_0000);
		push_write(5, 32'h00F8_FC08);
		push_read(0, 0);
		push_read(11'h7FF, 11'h7FF);

		// Small upscaled frame in both output formats, with edge clamping.
		wait_idle();
		set_frame(4, 3, 8, 6, 1'b0);
		for (int a = 0; a < 12; a++)
			push_write(nns_pkg::ADDR_W'(a),
				(a == 0) ? 32'hFFFF_FFFF : (a == 1) ? 32'h0 : $urandom());
		push_read(0, 0);
		push_read(7, 5);
		push_read(11'h7FF, 11'h7FF);
		wait_idle();
		set_frame(4, 3, 8, 6, 1'b1);
		push_read(3, 1);
		push_read(7, 5);

		// Zero destination size acts as one.
		wait_idle();
		set_frame(4, 3, 0, 0, 1'b0);
		push_read(1, 1);
		push_read(0, 0);

		// Zero source height keeps the source row at zero.
		wait_idle();
		set_frame(4, 0, 8, 6, 1'b0);
		push_read(5, 5);

		// Large frame: a source index past the store reads as zero.
		wait_idle();
		set_frame(2048, 2048, 2048, 2048, 1'b0);
		push_read(0, 1000);
		push_read(5, 0);

		// Random phases, sender gaps light and receiver gaps heavy.
		run_phase(4, 3, 7, 5, 1'b0, 80, 1'b0);
		run_phase(13, 9, 5, 4, 1'b1, 110, 1'b1);
		run_phase(1, 1, 2048, 2048, 1'b0, 100, 1'b0);
		run_phase(2048, 2048, 1, 1, 1'b1, 80, 1'b0);

		// Gaps swapped between the channels.
		wait_idle();
		snd_idle_pct = 48;
		rcv_idle_pct = 31;
		run_phase(4095, 4095, 0, 0, 1'b0, 80, 1'b0);
		run_phase(0, 5, 3, 3, 1'b1, 60, 1'b0);
		run_phase(6, 0, 9, 4, 1'b1, 80, 1'b0);
		run_phase($urandom_range(1, 16), $urandom_range(0, 12), $urandom_range(1, 40),
			$urandom_range(1, 40), 1'($urandom_range(1)), 70, 1'b0);

		// No gaps at all.
		wait_idle();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		repeat (2)
			run_phase($urandom_range(1, 16), $urandom_range(0, 12), $urandom_range(1, 40),
				$urandom_range(1, 40), 1'($urandom_range(1)), 70, 1'b0);

		// Drain, then allow time for any stray word.
		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (due_pixels.size() != 0)
			report_mismatch($sformatf("%0d expected words never returned", due_pixels.size()));
		if (err_cnt == 0)
			$display("nearest_neighbor_scaler_rgb565_core test passed");
		else
			$display("nearest_neighbor_scaler_rgb565_core test failed");
		$finish;
	end

endmodule
